/* rtl/servo_pulse_generator_core_macros.svh */
// Assertion macros used by the servo pulse generator RTL.
`ifndef SERVO_PULSE_GENERATOR_CORE_MACROS_SVH
`define SERVO_PULSE_GENERATOR_CORE_MACROS_SVH

// Concurrent assertion on an explicit clock and active-low reset.
`define SPG_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Concurrent assertion on the block clock and reset.
`define SPG_ASSERT(label, prop, msg) \
  `SPG_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

/* rtl/spg_pkg.sv */
// Types, constants and helper functions of the servo pulse generator.
package spg_pkg;

  // Item command codes.
  typedef enum logic [1:0] {
    CmdTick     = 2'd0,
    CmdSetDrive = 2'd1,
    CmdSetMount = 2'd2
  } cmd_e;

  // Configuration register indexes (byte address bits [3:2]).
  typedef enum logic [1:0] {
    RegPeriod      = 2'd0,
    RegMotorCenter = 2'd1,
    RegMountZero   = 2'd2
  } reg_e;

  localparam int ApbAddrW = 4;
  localparam int ApbDataW = 32;
  localparam int CfgW     = 16;

  localparam int SpeedLimit = 50;
  localparam int AngleLimit = 180;
  localparam int SpeedGain  = 20;
  localparam int AngleGain  = 11;
  localparam int AngleReset = 90;

  localparam logic [CfgW-1:0] PeriodReset      = 16'd20000;
  localparam logic [CfgW-1:0] MotorCenterReset = 16'd1500;
  localparam logic [CfgW-1:0] MountZeroReset   = 16'd500;

  // Pulse width as a signed value: 16-bit base plus a signed offset.
  localparam int WidthW = 18;

  typedef struct packed {
    logic [CfgW-1:0] period_ticks;
    logic [CfgW-1:0] motor_center_width;
    logic [CfgW-1:0] mount_zero_width;
  } cfg_t;

  typedef struct packed {
    logic signed [6:0] right_cmd;
    logic signed [6:0] left_cmd;
    logic [7:0]        pan_cmd;
    logic [7:0]        tilt_cmd;
  } cmds_t;

  typedef struct packed {
    logic right_pulse;
    logic left_pulse;
    logic pan_pulse;
    logic tilt_pulse;
  } pulses_t;

  // Limit a drive speed to the symmetric speed range.
  function automatic logic signed [6:0] clamp_speed(input logic signed [7:0] s);
    logic signed [6:0] r;
    if (s > $signed(8'(SpeedLimit))) begin
      r = 7'(SpeedLimit);
    end else if (s < -$signed(8'(SpeedLimit))) begin
      r = -$signed(7'(SpeedLimit));
    end else begin
      r = s[6:0];
    end
    return r;
  endfunction

  // Limit a mount angle to the top of the angle range.
  function automatic logic [7:0] clamp_angle(input logic [7:0] a);
    return (a > 8'(AngleLimit)) ? 8'(AngleLimit) : a;
  endfunction

endpackage

/* rtl/servo_pulse_generator_core.sv */
// Top level of the four-channel servo pulse generator.
// Input channel (in_valid_i / in_stall_o) carries items: a tick advances the
// period counter, a set item replaces the drive speeds or the mount angles.
// Output channel (out_valid_o / out_stall_i) carries one beat per item with
// the four pulse levels, computed from the count before the item and the
// commands after it.
// An accepted item is held in the input register; when it moves on, its
// levels are computed and loaded into the result register, which holds the
// beat on the output. One item per cycle is sustained while the receiver
// does not stall; the single pass from input register to result register
// sets that figure. When the receiver stalls, the result register holds its
// beat and the input register takes one more item before in_stall_o rises.
// Reset clears both registers' valid flags, sets the counter to zero, the
// speeds to zero, the angles to ninety degrees and the APB registers to a
// 20000-tick period, 1500-tick center width and 500-tick zero width.
// The user must write configuration through the APB port only while no item
// is in flight; the block itself does not enforce this.
`include "servo_pulse_generator_core_macros.svh"

module servo_pulse_generator_core #(
  parameter int COUNT_BITS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // APB configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [spg_pkg::ApbAddrW-1:0] paddr,
  input  logic [spg_pkg::ApbDataW-1:0] pwdata,
  output logic [spg_pkg::ApbDataW-1:0] prdata,
  output logic                         pready,
  // Item input
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   cmd_i,
  input  logic signed [7:0]            right_speed_i,
  input  logic signed [7:0]            left_speed_i,
  input  logic [7:0]                   pan_angle_i,
  input  logic [7:0]                   tilt_angle_i,
  // Result output
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         right_pulse_o,
  output logic                         left_pulse_o,
  output logic                         pan_pulse_o,
  output logic                         tilt_pulse_o
);

  spg_pkg::cfg_t         cfg;
  spg_pkg::cmds_t        cmds_next, cmds_q;
  spg_pkg::pulses_t      pulses_d, pulses_q;
  logic [COUNT_BITS-1:0] phase;

  logic                  in_valid_q;
  logic [1:0]            cmd_q;
  logic signed [7:0]     right_speed_q, left_speed_q;
  logic [7:0]            pan_angle_q, tilt_angle_q;
  logic                  out_valid_q;
  logic                  advance;
  logic                  in_take;
  logic                  tick;

  // The held item moves on when the result register is free or draining.
  assign advance    = in_valid_q & (~out_valid_q | ~out_stall_i);
  assign in_stall_o = in_valid_q & ~advance;
  assign in_take    = in_valid_i & ~in_stall_o;
  assign tick       = advance & (cmd_q == spg_pkg::CmdTick);

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      cmd_q         <= cmd_i;
      right_speed_q <= right_speed_i;
      left_speed_q  <= left_speed_i;
      pan_angle_q   <= pan_angle_i;
      tilt_angle_q  <= tilt_angle_i;
    end
  end

  spg_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  spg_cmd_store u_cmds (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .advance_i     (advance),
    .cmd_i         (cmd_q),
    .right_speed_i (right_speed_q),
    .left_speed_i  (left_speed_q),
    .pan_angle_i   (pan_angle_q),
    .tilt_angle_i  (tilt_angle_q),
    .cmds_next_o   (cmds_next),
    .cmds_q_o      (cmds_q)
  );

  spg_phase_counter #(
    .COUNT_BITS (COUNT_BITS)
  ) u_phase (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .tick_i   (tick),
    .period_i (cfg.period_ticks),
    .phase_o  (phase)
  );

  spg_level_unit #(
    .COUNT_BITS (COUNT_BITS)
  ) u_levels (
    .phase_i  (phase),
    .cfg_i    (cfg),
    .cmds_i   (cmds_next),
    .pulses_o (pulses_d)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (~out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      pulses_q <= pulses_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign right_pulse_o = pulses_q.right_pulse;
  assign left_pulse_o  = pulses_q.left_pulse;
  assign pan_pulse_o   = pulses_q.pan_pulse;
  assign tilt_pulse_o  = pulses_q.tilt_pulse;

  // A held item that cannot move on is still held next cycle.
  `SPG_ASSERT(a_item_kept, in_valid_q && !advance |=> in_valid_q, "held item lost")
  // A taken beat with nothing behind it empties the result register.
  `SPG_ASSERT(a_out_drains, out_valid_q && !out_stall_i && !advance |=> !out_valid_q,
              "result beat repeated")
  // The counter moves only on a tick item.
  `SPG_ASSERT(a_phase_hold, !tick |=> $stable(phase), "counter moved without a tick")
  // Drive commands change only on a drive set item.
  `SPG_ASSERT(a_drive_hold,
              !(advance && cmd_q == spg_pkg::CmdSetDrive) |=>
              $stable(cmds_q.right_cmd) && $stable(cmds_q.left_cmd),
              "drive command changed without a set item")

endmodule

/* rtl/spg_apb_regs.sv */
// APB configuration registers of the servo pulse generator.
module spg_apb_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [spg_pkg::ApbAddrW-1:0] paddr,
  input  logic [spg_pkg::ApbDataW-1:0] pwdata,
  output logic [spg_pkg::ApbDataW-1:0] prdata,
  output logic                         pready,
  output spg_pkg::cfg_t                cfg_o
);

  spg_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // Register write decode; addresses past the list are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (paddr[3:2])
        spg_pkg::RegPeriod:      cfg_d.period_ticks       = pwdata[spg_pkg::CfgW-1:0];
        spg_pkg::RegMotorCenter: cfg_d.motor_center_width = pwdata[spg_pkg::CfgW-1:0];
        spg_pkg::RegMountZero:   cfg_d.mount_zero_width   = pwdata[spg_pkg::CfgW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period_ticks       <= spg_pkg::PeriodReset;
      cfg_q.motor_center_width <= spg_pkg::MotorCenterReset;
      cfg_q.mount_zero_width   <= spg_pkg::MountZeroReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read mux.
  always_comb begin
    case (paddr[3:2])
      spg_pkg::RegPeriod:      prdata = spg_pkg::ApbDataW'(cfg_q.period_ticks);
      spg_pkg::RegMotorCenter: prdata = spg_pkg::ApbDataW'(cfg_q.motor_center_width);
      spg_pkg::RegMountZero:   prdata = spg_pkg::ApbDataW'(cfg_q.mount_zero_width);
      default:                 prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/spg_cmd_store.sv */
// Stored servo commands with clamping of new set items.
module spg_cmd_store (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                advance_i,
  input  logic [1:0]          cmd_i,
  input  logic signed [7:0]   right_speed_i,
  input  logic signed [7:0]   left_speed_i,
  input  logic [7:0]          pan_angle_i,
  input  logic [7:0]          tilt_angle_i,
  output spg_pkg::cmds_t      cmds_next_o,
  output spg_pkg::cmds_t      cmds_q_o
);

  spg_pkg::cmds_t cmds_q, cmds_d;

  // Commands as they stand after the current item.
  always_comb begin
    cmds_d = cmds_q;
    case (cmd_i)
      spg_pkg::CmdSetDrive: begin
        cmds_d.right_cmd = spg_pkg::clamp_speed(right_speed_i);
        cmds_d.left_cmd  = spg_pkg::clamp_speed(left_speed_i);
      end
      spg_pkg::CmdSetMount: begin
        cmds_d.pan_cmd  = spg_pkg::clamp_angle(pan_angle_i);
        cmds_d.tilt_cmd = spg_pkg::clamp_angle(tilt_angle_i);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cmds_q.right_cmd <= '0;
      cmds_q.left_cmd  <= '0;
      cmds_q.pan_cmd   <= 8'(spg_pkg::AngleReset);
      cmds_q.tilt_cmd  <= 8'(spg_pkg::AngleReset);
    end else if (advance_i) begin
      cmds_q <= cmds_d;
    end
  end

  assign cmds_next_o = cmds_d;
  assign cmds_q_o    = cmds_q;

endmodule

/* rtl/spg_phase_counter.sv */
// Period counter advanced by tick items.
module spg_phase_counter #(
  parameter int COUNT_BITS = 16
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      tick_i,
  input  logic [spg_pkg::CfgW-1:0]  period_i,
  output logic [COUNT_BITS-1:0]     phase_o
);

  localparam int CmpW = COUNT_BITS + spg_pkg::CfgW + 1;

  logic [COUNT_BITS-1:0] phase_q, phase_d;
  logic [COUNT_BITS:0]   phase_inc;

  // Wrap to zero at the end of the period; a zero period acts as one.
  always_comb begin
    phase_inc = {1'b0, phase_q} + 1'b1;
    if (CmpW'(phase_inc) >= CmpW'(period_i)) begin
      phase_d = '0;
    end else begin
      phase_d = phase_inc[COUNT_BITS-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
    end else if (tick_i) begin
      phase_q <= phase_d;
    end
  end

  assign phase_o = phase_q;

endmodule

/* rtl/spg_level_unit.sv */
// Pulse widths of the four channels and one comparator per channel.
module spg_level_unit #(
  parameter int COUNT_BITS = 16
) (
  input  logic [COUNT_BITS-1:0] phase_i,
  input  spg_pkg::cfg_t         cfg_i,
  input  spg_pkg::cmds_t        cmds_i,
  output spg_pkg::pulses_t      pulses_o
);

  localparam int WW   = spg_pkg::WidthW;
  localparam int LvlW = ((COUNT_BITS > WW) ? COUNT_BITS : WW) + 1;

  logic signed [WW-1:0]   center_w, zero_w;
  logic signed [WW-1:0]   right_w, left_w, pan_w, tilt_w;
  logic signed [LvlW-1:0] phase_s;

  // Width = base + gain * command, signed so a negative width stays low.
  always_comb begin
    center_w = $signed({2'b00, cfg_i.motor_center_width});
    zero_w   = $signed({2'b00, cfg_i.mount_zero_width});
    right_w  = center_w + WW'(cmds_i.right_cmd) * $signed(WW'(spg_pkg::SpeedGain));
    left_w   = center_w + WW'(cmds_i.left_cmd) * $signed(WW'(spg_pkg::SpeedGain));
    pan_w    = zero_w + $signed({10'd0, cmds_i.pan_cmd}) * $signed(WW'(spg_pkg::AngleGain));
    tilt_w   = zero_w + $signed({10'd0, cmds_i.tilt_cmd}) * $signed(WW'(spg_pkg::AngleGain));
  end

  // Output is high while the count is below the width.
  assign phase_s = $signed({{(LvlW - COUNT_BITS){1'b0}}, phase_i});

  assign pulses_o.right_pulse = phase_s < LvlW'(right_w);
  assign pulses_o.left_pulse  = phase_s < LvlW'(left_w);
  assign pulses_o.pan_pulse   = phase_s < LvlW'(pan_w);
  assign pulses_o.tilt_pulse  = phase_s < LvlW'(tilt_w);

endmodule
